### src/sorted_expiry_timer_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Sorted expiry timer queue: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_EXPIRY_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante
`define SETQ_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer queue check failed");

// Check cons in the cycle after ante
`define SETQ_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer queue check failed");

`endif

### src/setq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted expiry timer queue package
// Sizes, request codes and result status codes.
// ----------------------------------------------------------------------------
package setq_pkg;

	localparam int CAPACITY    = 64;
	localparam int NUM_HANDLES = 64;
	localparam int HDL_BITS    = 6;
	localparam int TIME_BITS   = 32;
	localparam int CNT_BITS    = 7;
	localparam int ACT_BITS    = 2;
	localparam int STAT_BITS   = 3;

	localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

	typedef logic [HDL_BITS-1:0]  hdl_t;
	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	// Request codes
	localparam logic [ACT_BITS-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACT_BITS-1:0] ACT_ADJUST = 2'd1;
	localparam logic [ACT_BITS-1:0] ACT_DELETE = 2'd2;
	localparam logic [ACT_BITS-1:0] ACT_TICK   = 2'd3;

	// Result status codes
	localparam logic [STAT_BITS-1:0] ST_DONE    = 3'd0;
	localparam logic [STAT_BITS-1:0] ST_PRESENT = 3'd1;
	localparam logic [STAT_BITS-1:0] ST_ABSENT  = 3'd2;
	localparam logic [STAT_BITS-1:0] ST_EXPIRED = 3'd3;
	localparam logic [STAT_BITS-1:0] ST_NONE    = 3'd4;

endpackage

### src/sorted_expiry_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted expiry timer queue
// Up to 64 timers kept in ascending expiry order in a circular order memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall): action, handle, expiry, now.
//   A request is taken when in_valid is high and in_stall is low. in_stall
//   is high while a request is being worked on.
//   Result channel (out_valid / out_stall): status, expired_handle, last.
//   Add, adjust and delete give one result; tick gives one result per
//   expired timer in queue order, or one "none expired" result. last marks
//   the final result of a request.
//   Sequencing: a single comparator and two memories with one read and one write
//   port (order list, expiry store) are stepped by a sequencer. Insert
//   examines one entry at a time from the tail (read, expiry fetch, compare);
//   delete scans every entry from the head (read, check); tick first counts
//   the due timers from the head, then reads and emits one result per timer.
//   An error result goes from the idle state straight to the response state.
//   The result register frees the request side: a new request may be taken
//   while the last result still waits; a stalled result holds its value and
//   stalls the sequencer only when it needs to deliver another result.
//   Reset clears the present flags, the count and the head pointer; the
//   memories need no clearing, so the block is ready right after reset.
// ----------------------------------------------------------------------------
`include "sorted_expiry_timer_queue_unit_defines.svh"

module sorted_expiry_timer_queue_unit
	import setq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACT_BITS-1:0]  action,
	input  logic [HDL_BITS-1:0]  handle,
	input  logic [TIME_BITS-1:0] expiry,
	input  logic [TIME_BITS-1:0] now,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STAT_BITS-1:0] status,
	output logic [HDL_BITS-1:0]  expired_handle,
	output logic                 last
);

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RESP = 4'd1;
	localparam logic [3:0] S_DRD  = 4'd2;
	localparam logic [3:0] S_DCHK = 4'd3;
	localparam logic [3:0] S_ITOP = 4'd4;
	localparam logic [3:0] S_IEXP = 4'd5;
	localparam logic [3:0] S_ICMP = 4'd6;
	localparam logic [3:0] S_TTOP = 4'd7;
	localparam logic [3:0] S_TEXP = 4'd8;
	localparam logic [3:0] S_TCMP = 4'd9;
	localparam logic [3:0] S_ERD  = 4'd10;
	localparam logic [3:0] S_EOUT = 4'd11;

	logic [3:0]             state_q;
	logic [ACT_BITS-1:0]    act_q;
	hdl_t                   hdl_q;
	time_t                  key_q;
	hdl_t                   cur_hdl_q;
	cnt_t                   idx_q;
	cnt_t                   cnt_q;
	cnt_t                   tk_q;
	hdl_t                   head_q;
	logic                   found_q;
	logic [STAT_BITS-1:0]   stat_q;
	logic [NUM_HANDLES-1:0] present_q;

	logic                   out_valid_q;
	logic [STAT_BITS-1:0]   status_q;
	hdl_t                   exp_hdl_q;
	logic                   last_q;

	// Memories
	hdl_t                   ord_mem [NUM_HANDLES];
	time_t                  exp_mem [NUM_HANDLES];
	hdl_t                   ord_rdata_q;
	time_t                  exp_rdata_q;

	logic                   in_accept;
	logic                   out_free;
	logic                   out_load;
	logic [STAT_BITS-1:0]   nxt_status;
	hdl_t                   nxt_hdl;
	logic                   nxt_last;
	cnt_t                   idx_m1;
	cnt_t                   rd_sum;
	cnt_t                   wr_sum;
	hdl_t                   ord_raddr;
	hdl_t                   ord_waddr;
	hdl_t                   ord_wdata;
	logic                   ord_we;
	logic                   exp_we;
	logic                   key_lt;
	logic                   emit_last;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Shared comparator: stored expiry strictly above the key
	assign key_lt = (exp_rdata_q > key_q);

	// Address arithmetic relative to the queue head, wrapping at depth
	assign idx_m1    = idx_q - cnt_t'(1);
	assign rd_sum    = cnt_t'(head_q) + ((state_q == S_ITOP) ? idx_m1 : idx_q);
	assign wr_sum    = cnt_t'(head_q) + ((state_q == S_DCHK) ? idx_m1 : idx_q);
	assign ord_raddr = rd_sum[HDL_BITS-1:0];
	assign ord_waddr = wr_sum[HDL_BITS-1:0];

	// Order memory writes: shift down on delete, shift up or place on insert
	assign ord_we = ((state_q == S_DCHK) && found_q) ||
		((state_q == S_ITOP) && (idx_q == '0)) || (state_q == S_ICMP);
	always_comb begin
		if (state_q == S_DCHK) begin
			ord_wdata = ord_rdata_q;
		end else if ((state_q == S_ICMP) && key_lt) begin
			ord_wdata = cur_hdl_q;
		end else begin
			ord_wdata = hdl_q;
		end
	end

	// Store the new expiry when an add or adjust is taken
	assign exp_we = in_accept &&
		(((action == ACT_ADD) && !present_q[handle] && (cnt_q < CAP_CNT)) ||
		((action == ACT_ADJUST) && present_q[handle]));

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		ord_rdata_q <= ord_mem[ord_raddr];
	end

	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[handle] <= expiry;
		end
		exp_rdata_q <= exp_mem[ord_rdata_q];
	end

	// Result selection
	assign emit_last = (idx_q == (tk_q - cnt_t'(1)));
	always_comb begin
		out_load   = 1'b0;
		nxt_status = stat_q;
		nxt_hdl    = '0;
		nxt_last   = 1'b1;
		if (state_q == S_RESP) begin
			out_load = out_free;
		end else if (state_q == S_EOUT) begin
			out_load   = out_free;
			nxt_status = ST_EXPIRED;
			nxt_hdl    = ord_rdata_q;
			nxt_last   = emit_last;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			exp_hdl_q   <= '0;
			last_q      <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			status_q    <= nxt_status;
			exp_hdl_q   <= nxt_hdl;
			last_q      <= nxt_last;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign expired_handle = exp_hdl_q;
	assign last           = last_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			act_q     <= ACT_ADD;
			hdl_q     <= '0;
			key_q     <= '0;
			cur_hdl_q <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			tk_q      <= '0;
			head_q    <= '0;
			found_q   <= 1'b0;
			stat_q    <= ST_DONE;
			present_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						act_q   <= action;
						hdl_q   <= handle;
						key_q   <= (action == ACT_TICK) ? now : expiry;
						idx_q   <= '0;
						found_q <= 1'b0;
						stat_q  <= ST_DONE;
						unique case (action)
							ACT_ADD: begin
								if (present_q[handle] || (cnt_q >= CAP_CNT)) begin
									stat_q  <= ST_PRESENT;
									state_q <= S_RESP;
								end else begin
									present_q[handle] <= 1'b1;
									idx_q             <= cnt_q;
									state_q           <= S_ITOP;
								end
							end
							ACT_ADJUST: begin
								if (!present_q[handle]) begin
									stat_q  <= ST_ABSENT;
									state_q <= S_RESP;
								end else begin
									state_q <= S_DRD;
								end
							end
							ACT_DELETE: begin
								if (!present_q[handle]) begin
									stat_q  <= ST_ABSENT;
									state_q <= S_RESP;
								end else begin
									present_q[handle] <= 1'b0;
									state_q           <= S_DRD;
								end
							end
							default: begin
								state_q <= S_TTOP;
							end
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				// Delete scan: find the handle, pull later entries down by one
				S_DRD: begin
					state_q <= S_DCHK;
				end
				S_DCHK: begin
					if (!found_q && (ord_rdata_q == hdl_q)) begin
						found_q <= 1'b1;
					end
					if (idx_q == (cnt_q - cnt_t'(1))) begin
						cnt_q <= cnt_q - cnt_t'(1);
						if (act_q == ACT_ADJUST) begin
							idx_q   <= cnt_q - cnt_t'(1);
							state_q <= S_ITOP;
						end else begin
							stat_q  <= ST_DONE;
							state_q <= S_RESP;
						end
					end else begin
						idx_q   <= idx_q + cnt_t'(1);
						state_q <= S_DRD;
					end
				end
				// Insert from the tail: move later-expiring entries up by one
				S_ITOP: begin
					if (idx_q == '0) begin
						cnt_q   <= cnt_q + cnt_t'(1);
						stat_q  <= ST_DONE;
						state_q <= S_RESP;
					end else begin
						state_q <= S_IEXP;
					end
				end
				S_IEXP: begin
					cur_hdl_q <= ord_rdata_q;
					state_q   <= S_ICMP;
				end
				S_ICMP: begin
					if (key_lt) begin
						idx_q   <= idx_m1;
						state_q <= S_ITOP;
					end else begin
						cnt_q   <= cnt_q + cnt_t'(1);
						stat_q  <= ST_DONE;
						state_q <= S_RESP;
					end
				end
				// Tick count pass: walk from the head while entries are due
				S_TTOP: begin
					if (idx_q == cnt_q) begin
						tk_q  <= idx_q;
						idx_q <= '0;
						if (idx_q == '0) begin
							stat_q  <= ST_NONE;
							state_q <= S_RESP;
						end else begin
							state_q <= S_ERD;
						end
					end else begin
						state_q <= S_TEXP;
					end
				end
				S_TEXP: begin
					state_q <= S_TCMP;
				end
				S_TCMP: begin
					if (!key_lt) begin
						idx_q   <= idx_q + cnt_t'(1);
						state_q <= S_TTOP;
					end else begin
						tk_q  <= idx_q;
						idx_q <= '0;
						if (idx_q == '0) begin
							stat_q  <= ST_NONE;
							state_q <= S_RESP;
						end else begin
							state_q <= S_ERD;
						end
					end
				end
				// Tick emit pass: one result per due entry, then advance head
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_free) begin
						present_q[ord_rdata_q] <= 1'b0;
						if (emit_last) begin
							head_q  <= head_q + tk_q[HDL_BITS-1:0];
							cnt_q   <= cnt_q - tk_q;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + cnt_t'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Assertions
	`SETQ_CHECK(a_cnt_bound, 1'b1, cnt_q <= CAP_CNT)
	`SETQ_CHECK(a_cnt_matches_flags, state_q == S_IDLE, $countones(present_q) == int'(cnt_q))
	`SETQ_CHECK_NEXT(a_expired_cleared, out_load && (nxt_status == ST_EXPIRED),
		!present_q[exp_hdl_q])
	`SETQ_CHECK_NEXT(a_add_sets_flag,
		in_accept && (action == ACT_ADD) && !present_q[handle] && (cnt_q < CAP_CNT),
		present_q[$past(handle)])

endmodule
